// File: design/rtp_header_checker_top_macros.svh
// Assertion macros used by the RTP header checker assertion checker file.
`ifndef RTP_HEADER_CHECKER_TOP_MACROS_SVH
`define RTP_HEADER_CHECKER_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define RTPHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RTPHC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/rtphc_pkg.sv
// Package: status codes, header layout, divide-by-nine constants and the result record.
`timescale 1ns / 1ps
package rtphc_pkg;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_PADDING     = 3'd3;
  localparam logic [2:0] ST_EXTENSION   = 3'd4;
  localparam logic [2:0] ST_SSRC_MISM   = 3'd5;
  localparam logic [2:0] ST_PT_MISM     = 3'd6;
  localparam logic [2:0] ST_CSRC_SHORT  = 3'd7;

  // Header layout
  localparam logic [6:0] POS_TS_FIRST   = 7'd4;
  localparam logic [6:0] POS_TS_LAST    = 7'd7;
  localparam logic [6:0] POS_SSRC_LAST  = 7'd11;
  localparam logic [6:0] POS_FIXED_END  = 7'd12;
  localparam logic [6:0] POS_MAX        = 7'd127;
  localparam logic [1:0] RTP_VERSION    = 2'd2;

  // floor(x/9) = (x * DIV9_RECIP) >> DIV9_SHIFT, exact for x < 2^15
  localparam int         DIV9_SHIFT     = 18;
  localparam logic [14:0] DIV9_RECIP    = 15'd29128;
  localparam logic [6:0] TS_SCALE       = 7'd100;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        packet_end;
    logic [2:0]  status;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] sequence_number;
    logic [35:0] timestamp_us;
    logic [31:0] stream_id;
    logic        sequence_gap;
    logic [15:0] sequence_diff;
  } result_t;

endpackage

// File: design/rtp_header_checker_top.sv
// RTP header checker: byte-serial header parse, stream lock and payload forward.
`timescale 1ns / 1ps
// A result is registered in the output register, or in the skid entry while it stalls.
// Throughput: one byte per cycle unless the skid entry is full (in_ready low).
// A two-entry output stage (result register plus skid) absorbs one result under stall.
// Timestamp scaling ts*100/9 is built incrementally as timestamp bytes arrive.
// Synchronous active-high reset clears position, lock, sequence and output valids.
module rtp_header_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic        packet_end,
  output logic [2:0]  status,
  output logic        marker,
  output logic [6:0]  payload_type,
  output logic [15:0] sequence_number,
  output logic [35:0] timestamp_us,
  output logic [31:0] stream_id,
  output logic        sequence_gap,
  output logic [15:0] sequence_diff
);
  import rtphc_pkg::*;

  // Parser state
  logic [6:0]  byte_position;
  logic [7:0]  first_header_byte;
  logic [7:0]  second_header_byte;
  logic [15:0] seq_field;
  logic [31:0] ssrc_field;
  logic [2:0]  error_code;
  // Timestamp scaled so far: value*100 = 9*ts_quot + ts_rem
  logic [35:0] ts_quot;
  logic [3:0]  ts_rem;

  // Stream lock and sequence tracking
  logic        stream_acquired;
  logic [31:0] locked_ssrc;
  logic [6:0]  locked_pt;
  logic        seq_acquired;
  logic [15:0] expected_seq;
  logic        gap_flag;
  logic [15:0] gap_amount;

  // Output stage
  result_t     out_q;
  result_t     skid_q;
  logic        skid_valid;

  logic        in_fire;
  logic        pkt_fire;
  logic        out_fire;

  // Header evaluation (meaningful at the last SSRC byte)
  logic [31:0] ssrc_full;
  logic [6:0]  pt_in;
  logic [2:0]  hdr_code;
  logic        hdr_acquire;
  logic        hdr_seq_upd;
  logic        gap_new;
  logic [15:0] amount_new;
  logic        at_hdr_end;

  logic [2:0]  err_eff;
  logic [6:0]  lpt_eff;
  logic [31:0] lssrc_eff;
  logic        gap_eff;
  logic [15:0] amount_eff;

  logic [6:0]  payload_start;
  logic        is_payload;
  logic        csrc_short;
  logic [2:0]  status_calc;

  // Incremental divide by nine
  logic        ts_first;
  logic        ts_byte;
  logic [14:0] ts_x;
  logic [29:0] ts_prod;
  logic [11:0] ts_q_step;
  logic [14:0] ts_r_full;

  logic        produce;
  result_t     res_new;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign pkt_fire = in_fire && !kind;
  assign out_fire = out_valid && out_ready;

  assign ssrc_full  = {ssrc_field[23:0], data_byte};
  assign pt_in      = second_header_byte[6:0];
  assign at_hdr_end = (byte_position == POS_SSRC_LAST);

  always_comb begin
    hdr_code    = ST_OK;
    hdr_acquire = 1'b0;
    hdr_seq_upd = 1'b0;
    if (first_header_byte[7:6] != RTP_VERSION) begin
      hdr_code = ST_BAD_VERSION;
    end else if (first_header_byte[5]) begin
      hdr_code = ST_PADDING;
    end else if (first_header_byte[4]) begin
      hdr_code = ST_EXTENSION;
    end else if (!stream_acquired) begin
      hdr_acquire = 1'b1;
      hdr_seq_upd = 1'b1;
    end else if (ssrc_full != locked_ssrc) begin
      hdr_code = ST_SSRC_MISM;
    end else if (pt_in != locked_pt) begin
      hdr_code = ST_PT_MISM;
    end else begin
      hdr_seq_upd = 1'b1;
    end
  end

  assign gap_new    = seq_acquired && (expected_seq != seq_field);
  assign amount_new = gap_new ? (seq_field - expected_seq) : 16'd0;

  // Values as they stand after this byte, for a packet ending at the header end
  assign err_eff    = at_hdr_end ? hdr_code : error_code;
  assign lpt_eff    = (at_hdr_end && hdr_acquire) ? pt_in : locked_pt;
  assign lssrc_eff  = (at_hdr_end && hdr_acquire) ? ssrc_full : locked_ssrc;
  assign gap_eff    = (at_hdr_end && hdr_seq_upd) ? gap_new : gap_flag;
  assign amount_eff = (at_hdr_end && hdr_seq_upd) ? amount_new : gap_amount;

  // Payload starts after the fixed header and CC CSRC words
  assign payload_start = POS_FIXED_END + {1'b0, first_header_byte[3:0], 2'b00};
  assign is_payload    = (byte_position >= POS_FIXED_END) &&
                         (byte_position >= payload_start) && (error_code == ST_OK);
  assign csrc_short    = ({1'b0, byte_position} + 8'd1) < {1'b0, payload_start};

  always_comb begin
    if (byte_position < POS_SSRC_LAST) begin
      status_calc = ST_SHORT;
    end else if (err_eff != ST_OK) begin
      status_calc = err_eff;
    end else if (csrc_short) begin
      status_calc = ST_CSRC_SHORT;
    end else begin
      status_calc = ST_OK;
    end
  end

  // value' * 100 = 9*(256*q) + (256*r + 100*b)
  assign ts_first  = (byte_position == POS_TS_FIRST);
  assign ts_byte   = (byte_position >= POS_TS_FIRST) && (byte_position <= POS_TS_LAST);
  assign ts_x      = (ts_first ? 15'd0 : {3'd0, ts_rem, 8'd0}) +
                     15'(data_byte * TS_SCALE);
  assign ts_prod   = 30'(ts_x) * 30'(DIV9_RECIP);
  assign ts_q_step = ts_prod[29:DIV9_SHIFT];
  assign ts_r_full = ts_x - ({ts_q_step, 3'd0} + 15'(ts_q_step));

  assign produce = pkt_fire && (last_byte || is_payload);

  always_comb begin
    res_new = '0;
    if (!last_byte) begin
      res_new.payload_byte  = data_byte;
      res_new.payload_valid = 1'b1;
    end else begin
      res_new.packet_end = 1'b1;
      res_new.status     = status_calc;
      if (status_calc == ST_OK) begin
        if (is_payload) begin
          res_new.payload_byte  = data_byte;
          res_new.payload_valid = 1'b1;
        end
        res_new.marker          = second_header_byte[7];
        res_new.payload_type    = lpt_eff;
        res_new.sequence_number = seq_field;
        res_new.timestamp_us    = ts_quot;
        res_new.stream_id       = lssrc_eff;
        res_new.sequence_gap    = gap_eff;
        res_new.sequence_diff   = amount_eff;
      end
    end
  end

  // Parser, lock and sequence registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      error_code      <= ST_OK;
      stream_acquired <= 1'b0;
      seq_acquired    <= 1'b0;
      gap_flag        <= 1'b0;
      gap_amount      <= '0;
    end else if (in_fire && kind) begin
      // relock: forget stream identity and sequence, packet parse continues
      stream_acquired <= 1'b0;
      seq_acquired    <= 1'b0;
    end else if (pkt_fire) begin
      if (byte_position == 7'd0) begin
        first_header_byte <= data_byte;
      end
      if (byte_position == 7'd1) begin
        second_header_byte <= data_byte;
      end
      if (byte_position == 7'd2 || byte_position == 7'd3) begin
        seq_field <= {seq_field[7:0], data_byte};
      end
      if (ts_byte) begin
        ts_quot <= (ts_first ? 36'd0 : {ts_quot[27:0], 8'd0}) + 36'(ts_q_step);
        ts_rem  <= ts_r_full[3:0];
      end
      if (byte_position > POS_TS_LAST && byte_position <= POS_SSRC_LAST) begin
        ssrc_field <= ssrc_full;
      end
      if (at_hdr_end) begin
        error_code <= hdr_code;
        if (hdr_acquire) begin
          stream_acquired <= 1'b1;
          locked_ssrc     <= ssrc_full;
          locked_pt       <= pt_in;
        end
        if (hdr_seq_upd) begin
          seq_acquired <= 1'b1;
          gap_flag     <= gap_new;
          gap_amount   <= amount_new;
          expected_seq <= seq_field + 16'd1;
        end
      end
      if (last_byte) begin
        byte_position <= '0;
        error_code    <= ST_OK;
        gap_flag      <= 1'b0;
        gap_amount    <= '0;
      end else if (byte_position != POS_MAX) begin
        byte_position <= byte_position + 7'd1;
      end
    end
  end

  // Result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_q      <= skid_q;
        out_valid  <= 1'b1;
        skid_q     <= res_new;
        skid_valid <= produce;
      end else begin
        out_q     <= res_new;
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_q     <= res_new;
      skid_valid <= 1'b1;
    end
  end

  assign payload_byte    = out_q.payload_byte;
  assign payload_valid   = out_q.payload_valid;
  assign packet_end      = out_q.packet_end;
  assign status          = out_q.status;
  assign marker          = out_q.marker;
  assign payload_type    = out_q.payload_type;
  assign sequence_number = out_q.sequence_number;
  assign timestamp_us    = out_q.timestamp_us;
  assign stream_id       = out_q.stream_id;
  assign sequence_gap    = out_q.sequence_gap;
  assign sequence_diff   = out_q.sequence_diff;

endmodule

// File: design/rtphc_checker.sv
// Port-level assertion checker for the RTP header checker, with its bind.
`timescale 1ns / 1ps
`include "rtp_header_checker_top_macros.svh"
module rtphc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic        payload_valid,
  input logic        packet_end,
  input logic [2:0]  status,
  input logic        sequence_gap,
  input logic [31:0] stream_id,
  input logic [35:0] timestamp_us
);
  import rtphc_pkg::*;

  `RTPHC_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

  `RTPHC_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(packet_end) && $stable(payload_byte) && $stable(status), "stalled result changed")

  `RTPHC_ASSERT(a_mid_payload, out_valid && !packet_end |-> payload_valid && status == ST_OK && stream_id == 32'd0 && !sequence_gap, "mid-packet result is not a bare payload transfer")

  `RTPHC_ASSERT(a_err_zero, out_valid && packet_end && status != ST_OK |-> !payload_valid && !sequence_gap && stream_id == 32'd0 && timestamp_us == 36'd0, "error result carries stream fields")

endmodule

bind rtp_header_checker_top rtphc_checker u_rtphc_checker (.*);
